@@ src/fbc_pkg.sv @@
// fbc_pkg: item types, status codes, character constants and character
// class helpers for the forward bracket closer.
// No dependencies.
`default_nettype none

package fbc_pkg;

  // bracket stack depth; nesting output is six bits wide
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned NEST_W      = 6;

  // length of the word operator
  localparam int unsigned KW_LEN = 8;
  localparam int unsigned KP_W   = 4;

  // result status codes
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_OPEN     = 3'd1,
    ST_CLOSED   = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_BADSTART = 3'd4,
    ST_GAVEUP   = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_e;

  // bracket kinds kept in the stack
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_ROUND  = 2'd1;
  localparam logic [1:0] KIND_SQUARE = 2'd2;
  localparam logic [1:0] KIND_CURLY  = 2'd3;

  // characters of interest
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_O  = 8'h6F;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // one input item
  typedef struct packed {
    logic [7:0] ch;
    logic       line_start;
    logic       search_start;
    logic       text_end;
  } in_item_t;

  // one result item
  typedef struct packed {
    status_e             status;
    logic [NEST_W-1:0]   nesting;
  } out_item_t;

  // letters of the word operator, by position
  function automatic logic [7:0] keyword_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0:    r = 8'h6F; // o
      3'd1:    r = 8'h70; // p
      3'd2:    r = 8'h65; // e
      3'd3:    r = 8'h72; // r
      3'd4:    r = 8'h61; // a
      3'd5:    r = 8'h74; // t
      3'd6:    r = 8'h6F; // o
      3'd7:    r = 8'h72; // r
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [1:0] kind_of(input logic [7:0] c);
    logic [1:0] k;
    if (c == CH_LPAREN || c == CH_RPAREN) begin
      k = KIND_ROUND;
    end else if (c == CH_LBRACK || c == CH_RBRACK) begin
      k = KIND_SQUARE;
    end else if (c == CH_LBRACE || c == CH_RBRACE) begin
      k = KIND_CURLY;
    end else begin
      k = KIND_NONE;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ src/forward_bracket_closer.sv @@
// forward_bracket_closer: top level, bracket and template angle matcher.
// Depends on fbc_pkg for item types, status codes and character helpers.
`default_nettype none

// Reads source text one character item per cycle and reports, for each
// character, the state of a forward bracket search started at a character
// marked search_start. Every accepted item yields exactly one result item.
// Throughput is one item per clock when not stalled; an item passes the input
// register, then the result register. The whole per-character update of the
// bracket stack (kept in flip-flops, STACK_DEPTH entries of a kind and a
// pending angle count) and of the operator keyword matcher is done in a
// single pass between those two registers, so the stack registers set the
// rate. The input side keeps accepting while a result waits downstream, as
// long as the result register is free or being emptied in the same cycle.
module forward_bracket_closer #(
  parameter int unsigned ANGLE_MAX = 15
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire fbc_pkg::in_item_t   in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      fbc_pkg::out_item_t  out_item_o
);
  import fbc_pkg::*;

  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ANG_W = $clog2(ANGLE_MAX + 1);

  // handshake and pipeline registers
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      fire;

  // search state
  logic             srch_q, srch_d;
  logic             chk_q, chk_d;
  logic [CNT_W-1:0] top_q, top_d;
  logic [ANG_W-1:0] base_q, base_d;

  // character trackers
  logic [7:0]       prev_q, prev_d;
  logic [KP_W-1:0]  kp_q, kp_d;
  logic             kbp_q, kbp_d;
  logic             pww_q, pww_d;

  // bracket stack, no reset: entries are written on push before any read
  logic [1:0]       kind_q  [STACK_DEPTH];
  logic [ANG_W-1:0] angle_q [STACK_DEPTH];

  // combinational work signals
  logic [7:0]       c;
  logic             ls, ss, te;
  logic [7:0]       pc;
  logic [KP_W-1:0]  kp;
  logic             kbp, pww;
  logic [CNT_W-1:0] eff_top, top_m1;
  logic [ANG_W-1:0] eff_base, ta, ta_new;
  logic [IDX_W-1:0] top_idx, push_idx;
  logic             top_zero, is_open3, is_close3;
  logic             do_scan, drop, push, pop, ta_wr, srch, chk;
  status_e          status;

  // handshake
  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // per-character update
  always_comb begin
    c  = in_q.ch;
    ls = in_q.line_start;
    ss = in_q.search_start;
    te = in_q.text_end;

    // trackers cleared on line start before use
    pc  = ls ? 8'h00 : prev_q;
    kp  = ls ? '0 : kp_q;
    kbp = ls ? 1'b0 : kbp_q;
    pww = ls ? 1'b0 : pww_q;

    // a new search starts from an empty stack
    eff_top  = ss ? '0 : top_q;
    eff_base = ss ? '0 : base_q;
    top_m1   = eff_top - CNT_W'(1);
    top_idx  = top_m1[IDX_W-1:0];
    push_idx = eff_top[IDX_W-1:0];
    top_zero = (eff_top == '0);
    ta       = top_zero ? eff_base : angle_q[top_idx];

    is_open3  = (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
    is_close3 = (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);

    status  = ST_IDLE;
    do_scan = 1'b0;
    drop    = 1'b0;
    srch    = srch_q;
    chk     = chk_q;
    push    = 1'b0;
    pop     = 1'b0;
    ta_wr   = 1'b0;
    ta_new  = ta;

    // start, second-character check and line-end give up
    if (ss) begin
      srch    = is_open3 || (c == CH_LT);
      chk     = (c == CH_LT);
      do_scan = srch;
      if (!srch) begin
        status = ST_BADSTART;
      end
    end else if (srch_q) begin
      if (chk_q && !ls && (c == CH_LT || c == CH_EQ)) begin
        status = ST_BADSTART;
        drop   = 1'b1;
      end else begin
        chk = 1'b0;
        if (ls && top_q == '0 && base_q == '0) begin
          status = ST_GAVEUP;
          drop   = 1'b1;
        end else begin
          do_scan = 1'b1;
        end
      end
    end

    // scan one character of an active search
    if (do_scan) begin
      status = ST_OPEN;
      if (is_open3) begin
        if (eff_top >= CNT_W'(STACK_DEPTH)) begin
          status = ST_OVERFLOW;
          drop   = 1'b1;
        end else begin
          push = 1'b1;
        end
      end else if (c == CH_LT) begin
        if (pc == CH_LT) begin
          // shift operator takes back a pending angle
          if (ta != '0) begin
            ta_wr  = 1'b1;
            ta_new = ta - ANG_W'(1);
            if (top_zero && ta == ANG_W'(1)) begin
              status = ST_MISMATCH;
              drop   = 1'b1;
            end
          end
        end else if (kp < KP_W'(KW_LEN)) begin
          if (ta >= ANG_W'(ANGLE_MAX)) begin
            status = ST_OVERFLOW;
            drop   = 1'b1;
          end else begin
            ta_wr  = 1'b1;
            ta_new = ta + ANG_W'(1);
          end
        end
      end else if (is_close3) begin
        ta_wr  = 1'b1;
        ta_new = '0;
        if (top_zero) begin
          status = ST_MISMATCH;
          drop   = 1'b1;
        end else if (kind_q[top_idx] != kind_of(c)) begin
          status = ST_MISMATCH;
          drop   = 1'b1;
        end else begin
          pop = 1'b1;
          if (eff_top == CNT_W'(1) && eff_base == '0) begin
            status = ST_CLOSED;
            drop   = 1'b1;
          end
        end
      end else if (c == CH_GT) begin
        // arrows and a > after operator and white space never close an angle
        if (!(pc == CH_MINUS || kbp) && ta != '0) begin
          ta_wr  = 1'b1;
          ta_new = ta - ANG_W'(1);
          if (top_zero && ta == ANG_W'(1)) begin
            status = ST_CLOSED;
            drop   = 1'b1;
          end
        end
      end else if (c == CH_SEMI) begin
        ta_wr  = 1'b1;
        ta_new = '0;
        if (top_zero) begin
          status = ST_MISMATCH;
          drop   = 1'b1;
        end
      end
    end

    // end of text with the search still open
    if (srch && !drop && te) begin
      status = ST_GAVEUP;
      drop   = 1'b1;
    end

    // next search state
    if (drop) begin
      srch_d = 1'b0;
      chk_d  = 1'b0;
      top_d  = '0;
      base_d = '0;
    end else begin
      srch_d = srch;
      chk_d  = chk;
      top_d  = push ? eff_top + CNT_W'(1) : (pop ? top_m1 : eff_top);
      base_d = (ta_wr && top_zero) ? ta_new : eff_base;
    end

    // keyword matcher for operator followed by spaces
    kbp_d = (kp == KP_W'(KW_LEN));
    if (kp == KP_W'(KW_LEN) && is_space(c)) begin
      kp_d = KP_W'(KW_LEN);
    end else if (kp != '0 && kp < KP_W'(KW_LEN) && c == keyword_char(kp[2:0])) begin
      kp_d = kp + KP_W'(1);
    end else if (c == CH_LOW_O && !pww) begin
      kp_d = KP_W'(1);
    end else begin
      kp_d = '0;
    end
    pww_d  = is_word(c);
    prev_d = c;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.status  <= status;
      out_q.nesting <= NEST_W'(top_d);
    end
  end

  // search and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_q <= 1'b0;
      chk_q  <= 1'b0;
      top_q  <= '0;
      base_q <= '0;
      prev_q <= 8'h00;
      kp_q   <= '0;
      kbp_q  <= 1'b0;
      pww_q  <= 1'b0;
    end else if (fire) begin
      srch_q <= srch_d;
      chk_q  <= chk_d;
      top_q  <= top_d;
      base_q <= base_d;
      prev_q <= prev_d;
      kp_q   <= kp_d;
      kbp_q  <= kbp_d;
      pww_q  <= pww_d;
    end
  end

  // bracket stack writes: push a new entry or update the top angle count
  always_ff @(posedge clk_i) begin
    if (fire && !drop) begin
      if (push) begin
        kind_q[push_idx]  <= kind_of(c);
        angle_q[push_idx] <= '0;
      end else if (ta_wr && !top_zero) begin
        angle_q[top_idx] <= ta_new;
      end
    end
  end

`ifndef ASSERT_OFF
  // stack depth never goes past its size
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= CNT_W'(STACK_DEPTH))
    else $error("bracket stack depth beyond its size");

  // no search means an empty stack and no pending angles
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !srch_q |-> (top_q == '0 && base_q == '0 && !chk_q))
    else $error("stack state left over without a search");

  // a finished or idle result reports zero nesting
  a_nest_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OPEN) |-> (out_q.nesting == '0))
    else $error("nonzero nesting on a result that is not open");

  // a processed item always lands in the result register
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item did not reach the result register");

  // open result carries the state that was stored with it
  a_open_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && status == ST_OPEN) |=> (srch_q && out_q.nesting == NEST_W'(top_q)))
    else $error("open result does not match stored search state");
`endif

endmodule

`default_nettype wire
